// ----- rtl/shfd_pkg.sv -----
// Shared types and constants for the sync-header frame deframer.
`timescale 1ns / 1ps
package shfd_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

  // Reset values of the sync header registers
  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hAF;

  // Result queue depth
  localparam int unsigned QDEPTH = 2;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_FUNC  = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CHECK = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] function_code;
    logic [7:0] frame_length;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
  } result_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;
  } cfg_wr_t;

endpackage

// ----- rtl/sync_header_frame_deframer_top.sv -----
// Top level of the sync-header frame deframer.
//
// Input channel in_valid/in_ready/in_rx_byte takes one received byte per
// beat. The block hunts for the two-byte sync header (registers 0 and 1,
// reset 0xAA and 0xAF), then takes function, length, payload and checksum.
// Each payload byte gives one result beat (kind payload, with its index);
// the checksum byte gives a frame-end beat marked good or bad, carrying the
// received checksum. Other bytes give no result.
// Output channel out_valid/out_ready carries kind, function code, frame
// length, payload byte and byte index.
// Configuration port cfg_valid/cfg_ready/cfg_index/cfg_data is always ready;
// write it only while the block is idle.
// A result is written into the result queue when its byte is taken.
// Throughput: one byte per cycle while in_ready is high.
// A two-entry result queue parts the sides: when the receiver stalls, bytes
// are still taken until the queue is full, then in_ready drops.
// Reset (rst_n, synchronous) restores the sync registers, starts the hunt
// with no previous byte and empties the queue.
`timescale 1ns / 1ps
module sync_header_frame_deframer_top import shfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_function_code,
  output logic [7:0]           out_frame_length,
  output logic [7:0]           out_payload_byte,
  output logic [7:0]           out_byte_index
);

  cfg_wr_t cfg_wr;
  logic    in_beat;
  logic    push;
  logic    full;
  result_t push_data;
  result_t head;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  assign in_ready = !full;
  assign in_beat  = in_valid && in_ready;

  shfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_wr),
    .in_beat    (in_beat),
    .in_rx_byte (in_rx_byte),
    .push       (push),
    .push_data  (push_data)
  );

  shfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (head)
  );

  assign out_kind          = head.kind;
  assign out_function_code = head.function_code;
  assign out_frame_length  = head.frame_length;
  assign out_payload_byte  = head.payload_byte;
  assign out_byte_index    = head.byte_index;

endmodule

// ----- rtl/shfd_front.sv -----
// Front part: sync hunt, frame parsing and checksum, one beat per cycle.
`timescale 1ns / 1ps
module shfd_front import shfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_wr_t    cfg_wr,
  input  logic       in_beat,
  input  logic [7:0] in_rx_byte,
  output logic       push,
  output result_t    push_data
);

  phase_t     state_r, state_nxt;
  logic [7:0] sync_first_r, sync_second_r;
  logic [7:0] prev_byte_r, prev_byte_nxt;
  logic       prev_valid_r, prev_valid_nxt;
  logic [7:0] func_r, func_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       emit;

  // Sync header registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_wr.data;
        CFG_SYNC_SECOND: sync_second_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= PH_HUNT;
      prev_byte_r  <= 8'd0;
      prev_valid_r <= 1'b0;
      func_r       <= 8'd0;
      len_r        <= 8'd0;
      count_r      <= 8'd0;
      sum_r        <= 8'd0;
    end else if (in_beat) begin
      state_r      <= state_nxt;
      prev_byte_r  <= prev_byte_nxt;
      prev_valid_r <= prev_valid_nxt;
      func_r       <= func_nxt;
      len_r        <= len_nxt;
      count_r      <= count_nxt;
      sum_r        <= sum_nxt;
    end
  end

  // Classify the byte and work out the next state
  always_comb begin
    state_nxt      = state_r;
    prev_byte_nxt  = prev_byte_r;
    prev_valid_nxt = prev_valid_r;
    func_nxt       = func_r;
    len_nxt        = len_r;
    count_nxt      = count_r;
    sum_nxt        = sum_r;
    emit           = 1'b0;
    push_data.kind          = KIND_PAYLOAD;
    push_data.function_code = func_r;
    push_data.frame_length  = len_r;
    push_data.payload_byte  = in_rx_byte;
    push_data.byte_index    = 8'd0;
    case (state_r)
      PH_FUNC: begin
        func_nxt  = in_rx_byte;
        sum_nxt   = sum_r + in_rx_byte;
        state_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_nxt   = in_rx_byte;
        sum_nxt   = sum_r + in_rx_byte;
        count_nxt = 8'd0;
        state_nxt = (in_rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        emit                 = 1'b1;
        push_data.byte_index = count_r;
        sum_nxt              = sum_r + in_rx_byte;
        count_nxt            = count_r + 8'd1;
        if (count_nxt == len_r) state_nxt = PH_CHECK;
      end
      PH_CHECK: begin
        emit           = 1'b1;
        push_data.kind = (in_rx_byte == sum_r) ? KIND_GOOD : KIND_BAD;
        state_nxt      = PH_HUNT;
        prev_valid_nxt = 1'b0;
        prev_byte_nxt  = 8'd0;
      end
      default: begin
        // Hunt: previous byte and current byte against the header
        if (prev_valid_r && prev_byte_r == sync_first_r && in_rx_byte == sync_second_r) begin
          sum_nxt        = sync_first_r + sync_second_r;
          state_nxt      = PH_FUNC;
          prev_valid_nxt = 1'b0;
          prev_byte_nxt  = 8'd0;
        end else begin
          state_nxt      = PH_HUNT;
          prev_byte_nxt  = in_rx_byte;
          prev_valid_nxt = 1'b1;
        end
      end
    endcase
  end

  assign push = in_beat && emit;

endmodule

// ----- rtl/shfd_queue.sv -----
// Back part: short result queue whose head drives the output channel.
`timescale 1ns / 1ps
module shfd_queue import shfd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  localparam int unsigned PTR_W = $clog2(QDEPTH);

  result_t            mem_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]     count_r;
  logic               pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign full      = (count_r == (PTR_W+1)'(QDEPTH));
  assign out_data  = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the sync-header frame deframer.
`timescale 1ns / 1ps
module tb_top;
  import shfd_pkg::*;

  typedef logic [7:0] bytes_t[$];

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 40;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SYNC_FIRST;
  logic [7:0]           cfg_data = 8'h00;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_kind;
  logic [7:0]           out_function_code;
  logic [7:0]           out_frame_length;
  logic [7:0]           out_payload_byte;
  logic [7:0]           out_byte_index;

  // Idling control and bookkeeping
  logic    idle_on = 1'b1;
  logic    hold_off = 1'b0;
  int      stall_left = 0;
  int      err_cnt = 0;
  int      sent_cnt = 0;
  int      cycle_cnt = 0;
  result_t pending_results[$];

  // Parser copy used for prediction
  logic [7:0] sync1 = SYNC_FIRST_RST;
  logic [7:0] sync2 = SYNC_SECOND_RST;
  phase_t     cur_phase = PH_HUNT;
  logic [7:0] prev_byte = 8'h00;
  logic       prev_valid = 1'b0;
  logic [7:0] held_fn = 8'h00;
  logic [7:0] held_len = 8'h00;
  logic [7:0] pay_cnt = 8'h00;
  logic [7:0] run_sum = 8'h00;

  sync_header_frame_deframer_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_function_code (out_function_code),
    .out_frame_length  (out_frame_length),
    .out_payload_byte  (out_payload_byte),
    .out_byte_index    (out_byte_index)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Advance the parser copy by one byte and queue any result it gives
  function automatic void step_deframer(input logic [7:0] b);
    result_t r;
    r.function_code = held_fn;
    r.frame_length  = held_len;
    r.payload_byte  = b;
    r.byte_index    = 8'h00;
    case (cur_phase)
      PH_FUNC: begin
        held_fn   = b;
        run_sum   = run_sum + b;
        cur_phase = PH_LEN;
      end
      PH_LEN: begin
        held_len  = b;
        run_sum   = run_sum + b;
        pay_cnt   = 8'h00;
        cur_phase = (b == 8'h00) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        r.kind       = KIND_PAYLOAD;
        r.byte_index = pay_cnt;
        pending_results.push_back(r);
        run_sum = run_sum + b;
        pay_cnt = pay_cnt + 8'd1;
        if (pay_cnt == held_len) cur_phase = PH_CHECK;
      end
      PH_CHECK: begin
        r.kind = (b == run_sum) ? KIND_GOOD : KIND_BAD;
        pending_results.push_back(r);
        cur_phase  = PH_HUNT;
        prev_valid = 1'b0;
        prev_byte  = 8'h00;
      end
      default: begin
        if (prev_valid && prev_byte == sync1 && b == sync2) begin
          run_sum    = sync1 + sync2;
          cur_phase  = PH_FUNC;
          prev_valid = 1'b0;
          prev_byte  = 8'h00;
        end else begin
          cur_phase  = PH_HUNT;
          prev_byte  = b;
          prev_valid = 1'b1;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got 0x%0h want 0x%0h at cycle %0d", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result kind", out_kind, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_kind != want.kind)
          report_mismatch("kind", out_kind, want.kind);
        if (out_function_code != want.function_code)
          report_mismatch("function_code", out_function_code, want.function_code);
        if (out_frame_length != want.frame_length)
          report_mismatch("frame_length", out_frame_length, want.frame_length);
        if (out_payload_byte != want.payload_byte)
          report_mismatch("payload_byte", out_payload_byte, want.payload_byte);
        if (out_byte_index != want.byte_index)
          report_mismatch("byte_index", out_byte_index, want.byte_index);
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offer one byte, hold it until the beat is taken, then predict
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    step_deframer(b);
    sent_cnt++;
  endtask

  // Send header, function, length, payload and checksum; corrupt flips the sum
  task automatic send_frame(input logic [7:0] fn, input bytes_t pl, input bit corrupt);
    logic [7:0] sum;
    logic [7:0] len;
    len = 8'(pl.size());
    sum = sync1 + sync2 + fn + len;
    foreach (pl[i]) sum = sum + pl[i];
    if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sync1);
    send_byte(sync2);
    send_byte(fn);
    send_byte(len);
    foreach (pl[i]) send_byte(pl[i]);
    send_byte(sum);
  endtask

  // Drop valid and wait for every expected result, plus a little slack
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Hold one register write beat until taken
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SYNC_FIRST) sync1 = val;
    else sync2 = val;
  endtask

  task automatic set_sync(input logic [7:0] first, input logic [7:0] second);
    drain_results();
    write_cfg(CFG_SYNC_FIRST, first);
    write_cfg(CFG_SYNC_SECOND, second);
    cfg_valid <= 1'b0;
  endtask

  // Reset header: lone second byte, zero length, header inside payload, bad sum
  task automatic test_directed_default();
    bytes_t pl;
    send_byte(8'hAF);
    pl = {};
    send_frame(8'h00, pl, 1'b0);
    pl = {8'hAA, 8'hAF};
    send_frame(8'hFF, pl, 1'b1);
    send_byte(8'hAA);
    pl = {8'h00, 8'hFF, 8'h80};
    send_frame(8'h7F, pl, 1'b0);
  endtask

  // Extreme and repeated header values; hunt restart right after a frame
  task automatic test_sync_registers();
    bytes_t pl;
    set_sync(8'h00, 8'hFF);
    pl = {8'h5A};
    send_frame(8'h01, pl, 1'b0);
    send_byte(8'hFF);
    pl = {8'hFF, 8'h00};
    send_frame(8'hC3, pl, 1'b0);
    set_sync(8'hFF, 8'h00);
    pl = {8'h00};
    send_frame(8'h80, pl, 1'b1);
    set_sync(8'h55, 8'h55);
    send_byte(8'h00);
    pl = {8'h55, 8'h55, 8'h55};
    send_frame(8'h12, pl, 1'b0);
  endtask

  // Stall the receiver while a long frame streams in, so the input backs up
  task automatic test_backpressure();
    bytes_t pl;
    set_sync(SYNC_FIRST_RST, SYNC_SECOND_RST);
    pl = {};
    repeat (20) pl.push_back(8'($urandom));
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    send_frame(8'($urandom), pl, 1'b0);
  endtask

  // Mostly well-formed frames with random content, some noise and broken headers
  task automatic test_random_frames(input int n_items);
    bytes_t pl;
    int     start;
    int     sel;
    int     pick;
    int     len;
    start = sent_cnt;
    while (sent_cnt - start < n_items) begin
      sel = $urandom_range(0, 7);
      if (sel < 6) begin
        pick = $urandom_range(0, 99);
        if (pick == 0) len = 255;
        else if (pick < 10) len = $urandom_range(9, 40);
        else len = $urandom_range(0, 8);
        pl = {};
        repeat (len) pl.push_back(8'($urandom));
        send_frame(8'($urandom), pl, $urandom_range(0, 3) == 0);
      end else if (sel == 6) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else begin
        // header cut short after its first byte
        send_byte(sync1);
        send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_default();
    test_sync_registers();
    test_backpressure();
    set_sync(SYNC_FIRST_RST, SYNC_SECOND_RST);
    test_random_frames(300);
    set_sync(8'($urandom), 8'($urandom));
    test_random_frames(250);
    idle_on <= 1'b0;
    set_sync(SYNC_FIRST_RST, SYNC_SECOND_RST);
    test_random_frames(250);
    drain_results();
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
